[hw/rtl/skbh_pkg.sv]
// Package for the string key bucket hash block.
// Holds widths, limits, hash mix functions and the queue types; depends on nothing.
package skbh_pkg;

   localparam int unsigned HASH_W       = 32;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned BUCKET_W     = 17;
   localparam int unsigned INDEX_W      = 16;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned DIV_CNT_W    = $clog2(HASH_W);

   localparam logic [BUCKET_W-1:0] MAX_BUCKETS        = 17'd65536;
   localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RESET = 17'd1024;

   // Register index of bucket_count within the configuration space.
   localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

   typedef logic [HASH_W-1:0]   hash_type;
   typedef logic [BUCKET_W-1:0] bucket_type;

   typedef struct packed {
      logic     valid;
      hash_type hash;
   } queue_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic hash_type fold_byte(input hash_type h_arg, input logic [BYTE_W-1:0] b);
      hash_type h;
      h = h_arg + {{(HASH_W-BYTE_W){1'b0}}, b};
      h = h + (h << 9);
      h = h ^ (h >> 19);
      return h;
   endfunction

   function automatic hash_type final_mix(input hash_type h_arg);
      hash_type h;
      h = h_arg + (h_arg << 3);
      h = h ^ (h >> 17);
      h = h + (h << 11);
      return h;
   endfunction

   // A zero count acts as one bucket; counts above the limit saturate.
   function automatic bucket_type effective_buckets(input bucket_type n);
      bucket_type r;
      r = n;
      if (n == '0) begin
         r = {{(BUCKET_W-1){1'b0}}, 1'b1};
      end else if (n > MAX_BUCKETS) begin
         r = MAX_BUCKETS;
      end
      return r;
   endfunction

endpackage

[hw/rtl/skbh_if.sv]
// Channel interfaces for the key byte stream and the hash results.
// Depends on skbh_pkg for field widths.
interface skbh_req_if;
   import skbh_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] key_byte;
   logic              byte_valid;
   logic              key_end;

   modport source (output valid, key_byte, byte_valid, key_end, input ready);
   modport sink   (input valid, key_byte, byte_valid, key_end, output ready);
endinterface

interface skbh_rsp_if;
   import skbh_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] bucket_index;
   logic [HASH_W-1:0]  full_hash;

   modport source (output valid, bucket_index, full_hash, input ready);
   modport sink   (input valid, bucket_index, full_hash, output ready);
endinterface

[hw/rtl/string_key_bucket_hash.sv]
// Top level of the string key bucket hash block: front end, key queue, back end
// and the bucket_count register. Depends on skbh_pkg, the channel interfaces,
// skbh_front, skbh_queue and skbh_back.
//
// The front end takes one key byte per cycle and never stalls while the queue
// of finished keys has room. Each key that ends is queued (four deep) and the
// back end takes one key at a time through the final mix, the bit-serial
// divider that forms bucket_index, and a wait until the result is transferred.
// The slower of the byte stream and the divider sets the rate. The bucket_count
// register at address 0 resets to 1024; a count of zero acts as one bucket and
// counts above 65536 act as 65536. Write it only while idle.
module string_key_bucket_hash (
   input  logic                                clock,
   input  logic                                reset,
   skbh_req_if.sink                            req_chan,
   skbh_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [skbh_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [skbh_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [skbh_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import skbh_pkg::*;

   bucket_type       bucket_count_ff, bucket_count_in;
   bucket_type       divisor;
   queue_push_type   q_push;
   queue_status_type q_status;
   hash_type         q_head;
   logic             q_pop;
   logic             csr_write;
   logic             csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1] == REG_BUCKET_COUNT);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      bucket_count_in = bucket_count_ff;
      if (csr_write && csr_hit) begin
         bucket_count_in = pwdata[BUCKET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   assign prdata  = csr_hit ? {{(CSR_DATA_W-BUCKET_W){1'b0}}, bucket_count_ff} : '0;
   assign divisor = effective_buckets(bucket_count_ff);

   skbh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_status (q_status),
      .q_push   (q_push)
   );

   skbh_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .pop    (q_pop),
      .head   (q_head),
      .status (q_status)
   );

   skbh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_empty (q_status.empty),
      .q_pop   (q_pop),
      .divisor (divisor),
      .rsp     (rsp_chan)
   );

   // A finished key must never be offered to a full queue.
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push.valid && q_status.full))
      else $error("key hash pushed into a full queue");

   // The reduced index always lies below the effective bucket count.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ({1'b0, rsp_chan.bucket_index} < divisor))
      else $error("bucket_index not below the bucket count");

   // A zero hash, as from an empty key, reduces to bucket zero.
   a_zero_hash_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.full_hash == '0)) |-> (rsp_chan.bucket_index == '0))
      else $error("zero hash gave a nonzero bucket_index");

   // The back end only takes a key from the queue when one is there.
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

endmodule

[hw/rtl/skbh_front.sv]
// Front end: takes key bytes, folds them into the accumulator, and queues each
// finished (unmixed) key hash. Depends on skbh_pkg and skbh_req_if.
module skbh_front (
   input  logic                       clock,
   input  logic                       reset,
   skbh_req_if.sink                   req,
   input  skbh_pkg::queue_status_type q_status,
   output skbh_pkg::queue_push_type   q_push
);
   import skbh_pkg::*;

   hash_type acc_ff;
   hash_type acc_in;
   hash_type folded;
   logic     accept;

   // Stall only when the queue cannot take another key.
   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      folded = req.byte_valid ? fold_byte(acc_ff, req.key_byte) : acc_ff;
      acc_in = acc_ff;
      if (accept) begin
         acc_in = req.key_end ? '0 : folded;
      end
   end

   assign q_push.valid = accept && req.key_end;
   assign q_push.hash  = folded;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

[hw/rtl/skbh_queue.sv]
// Short queue of key hashes between the front and back ends.
// Depends on skbh_pkg.
module skbh_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  skbh_pkg::queue_push_type   push,
   input  logic                       pop,
   output skbh_pkg::hash_type         head,
   output skbh_pkg::queue_status_type status
);
   import skbh_pkg::*;

   hash_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push.valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/skbh_back.sv]
// Back end: applies the final mix to a queued key hash, reduces it modulo the
// bucket count with a bit-serial divider, and holds the result for transfer.
// Depends on skbh_pkg and skbh_rsp_if.
module skbh_back (
   input  logic                 clock,
   input  logic                 reset,
   input  skbh_pkg::hash_type   q_head,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  skbh_pkg::bucket_type divisor,
   skbh_rsp_if.source           rsp
);
   import skbh_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   hash_type               hash_ff, hash_in;
   hash_type               dividend_ff, dividend_in;
   logic [INDEX_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic [BUCKET_W-1:0]    trial;
   logic [BUCKET_W-1:0]    trial_sub;
   hash_type               mixed;

   assign mixed     = final_mix(q_head);
   assign q_pop     = (state_ff == S_IDLE) && !q_empty;
   // The remainder stays below the divisor, so it fits the index width.
   assign trial     = {rem_ff, dividend_ff[HASH_W-1]};
   assign trial_sub = trial - divisor;

   always_comb begin
      state_in    = state_ff;
      hash_in     = hash_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               hash_in     = mixed;
               dividend_in = mixed;
               rem_in      = '0;
               count_in    = '1;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            rem_in      = (trial >= divisor) ? trial_sub[INDEX_W-1:0] : trial[INDEX_W-1:0];
            dividend_in = dividend_ff << 1;
            count_in    = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      hash_ff     <= hash_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      count_ff    <= count_in;
   end

   assign rsp.valid        = (state_ff == S_OUT);
   assign rsp.full_hash    = hash_ff;
   assign rsp.bucket_index = rem_ff;

endmodule

[dv/string_key_bucket_hash_tb.sv]
// Self-checking testbench for string_key_bucket_hash: streams key bytes, predicts each
// finished key's hash and bucket index, and checks every result transfer in order.
// Depends on skbh_pkg, the channel interfaces and the string_key_bucket_hash RTL.
module string_key_bucket_hash_tb;
   import skbh_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 800000;
   localparam int unsigned DRAIN_CYCLES  = 50;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned PHASE_ITEMS   = 85;
   localparam int unsigned SPARE_REG_IDX = 1;
   localparam logic [31:0] COUNT_MASK    = 32'h0001_FFFF;

   typedef struct packed {
      logic [BYTE_W-1:0] key_byte;
      logic              byte_valid;
      logic              key_end;
   } key_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0] bucket_index;
      logic [HASH_W-1:0]  full_hash;
   } hash_result_type;

   logic clock;
   logic reset;

   skbh_req_if req_chan ();
   skbh_rsp_if rsp_chan ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   string_key_bucket_hash dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready)
   );

   key_item_type    key_items[$];
   hash_result_type hash_results[$];

   logic [HASH_W-1:0] running_hash;
   logic [31:0]       bucket_setting;
   int unsigned       error_count;
   int unsigned       cycle_count;
   int unsigned       burst_left;
   int unsigned       gap_left;
   int unsigned       stall_mode;
   int unsigned       stall_cycle;
   int unsigned       keys_queued;
   int unsigned       keys_done;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("string_key_bucket_hash test failed");
         $finish;
      end
   end

   function automatic logic [HASH_W-1:0] absorb_byte(logic [HASH_W-1:0] acc,
                                                     logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] x;
      x = acc + HASH_W'(b);
      x = x + (x << 9);
      x = x ^ (x >> 19);
      return x;
   endfunction

   function automatic logic [HASH_W-1:0] finish_mix(logic [HASH_W-1:0] acc);
      logic [HASH_W-1:0] x;
      x = acc + (acc << 3);
      x = x ^ (x >> 17);
      x = x + (x << 11);
      return x;
   endfunction

   // Fold one accepted transfer into the running hash and queue the result it causes.
   function automatic void track_key_item(key_item_type it);
      hash_result_type r;
      logic [HASH_W-1:0] mixed;
      int unsigned buckets;
      if (it.byte_valid) begin
         running_hash = absorb_byte(running_hash, it.key_byte);
      end
      if (it.key_end) begin
         mixed = finish_mix(running_hash);
         running_hash = '0;
         buckets = bucket_setting;
         if (buckets == 0) begin
            buckets = 1;
         end else if (buckets > 65536) begin
            buckets = 65536;
         end
         r.full_hash = mixed;
         r.bucket_index = INDEX_W'(mixed % buckets);
         hash_results.push_back(r);
      end
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (error_count < MAX_REPORTS) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
         end
         error_count++;
      end
   endfunction

   function automatic void queue_item(logic [BYTE_W-1:0] b, logic bv, logic ke);
      key_item_type it;
      it.key_byte = b;
      it.byte_valid = bv;
      it.key_end = ke;
      key_items.push_back(it);
      if (ke) begin
         keys_queued++;
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin : drive_proc
      key_item_type cur;
      key_item_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            cur.key_byte = req_chan.key_byte;
            cur.byte_valid = req_chan.byte_valid;
            cur.key_end = req_chan.key_end;
            track_key_item(cur);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_chan.valid <= 1'b0;
            end else if (key_items.size() != 0) begin
               nxt = key_items.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.key_byte <= nxt.key_byte;
               req_chan.byte_valid <= nxt.byte_valid;
               req_chan.key_end <= nxt.key_end;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: holds ready under a stall pattern that is picked anew at random, from always ready to mostly stalled.
   always @(posedge clock) begin : watch_proc
      hash_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_mode <= 0;
         stall_cycle <= 0;
         keys_done <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            keys_done <= keys_done + 1;
            if (hash_results.size() == 0) begin
               if (error_count < MAX_REPORTS) begin
                  $display("unexpected result: index %0d hash %h",
                           rsp_chan.bucket_index, rsp_chan.full_hash);
               end
               error_count++;
            end else begin
               want = hash_results.pop_front();
               check_field("bucket_index", 32'(want.bucket_index),
                           32'(rsp_chan.bucket_index));
               check_field("full_hash", want.full_hash, rsp_chan.full_hash);
            end
         end
         stall_cycle <= stall_cycle + 1;
         if (stall_cycle % 64 == 63) begin
            stall_mode <= $urandom_range(0, 3);
         end
         case (stall_mode)
            0: begin
               rsp_chan.ready <= 1'b1;
            end
            1: begin
               rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_chan.ready <= ((stall_cycle % 7) < 3);
            end
         endcase
      end
   end

   task automatic csr_write(int unsigned reg_idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(reg_idx * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_idx == REG_BUCKET_COUNT) begin
         bucket_setting = value & COUNT_MASK;
      end
   endtask

   task automatic csr_read_check(int unsigned reg_idx, logic [31:0] want);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(reg_idx * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field("bucket_count readback", want, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One key of random length, with stray empty transfers and either end style.
   task automatic add_random_key(inout int unsigned produced);
      int unsigned len;
      int unsigned pick;
      logic [BYTE_W-1:0] b;
      logic end_on_byte;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         len = 0;
      end else if (pick <= 6) begin
         len = $urandom_range(1, 8);
      end else if (pick <= 8) begin
         len = $urandom_range(9, 24);
      end else begin
         len = $urandom_range(25, 70);
      end
      end_on_byte = (len != 0) && ($urandom_range(0, 2) != 0);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_item(BYTE_W'($urandom), 1'b0, 1'b0);
         end
         case ($urandom_range(0, 15))
            0: b = '0;
            1: b = '1;
            default: b = BYTE_W'($urandom);
         endcase
         queue_item(b, 1'b1, end_on_byte && (i == len - 1));
         produced++;
      end
      if (!end_on_byte) begin
         queue_item(BYTE_W'($urandom), 1'b0, 1'b1);
         produced++;
      end
   endtask

   // Every queued key must have come back before the bucket count may change.
   task automatic wait_idle();
      while (key_items.size() != 0 || req_chan.valid || hash_results.size() != 0 ||
             keys_done < keys_queued) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus_proc
      logic [31:0] count_plan[$];
      int unsigned produced;
      reset = 1'b1;
      cycle_count = 0;
      error_count = 0;
      keys_queued = 0;
      running_hash = '0;
      bucket_setting = 32'(BUCKET_COUNT_RESET);
      req_chan.valid = 1'b0;
      req_chan.key_byte = '0;
      req_chan.byte_valid = 1'b0;
      req_chan.key_end = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed keys under the reset bucket count.
      csr_read_check(REG_BUCKET_COUNT, 32'(BUCKET_COUNT_RESET));
      queue_item(8'hA5, 1'b0, 1'b1);
      queue_item(8'hFF, 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1);
      queue_item(8'hFF, 1'b1, 1'b1);
      queue_item(8'h01, 1'b1, 1'b0);
      queue_item(8'h80, 1'b1, 1'b0);
      queue_item(8'h5A, 1'b0, 1'b1);
      queue_item(8'hFF, 1'b1, 1'b0);
      queue_item(8'h3C, 1'b0, 1'b0);
      queue_item(8'h7F, 1'b1, 1'b1);
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1);
      queue_item(8'h00, 1'b0, 1'b1);
      produced = 0;
      while (produced < PHASE_ITEMS) add_random_key(produced);
      wait_idle();

      // The unused register slot must not disturb the bucket count.
      csr_write(SPARE_REG_IDX, 32'h0000_0005);
      csr_read_check(REG_BUCKET_COUNT, bucket_setting);

      count_plan = '{32'd0, 32'd1, 32'd65536, 32'd65537, 32'h0001_FFFF, 32'hFFFE_0007,
                     32'd65535, 32'd1000, 32'd3};
      count_plan.push_back(32'($urandom_range(2, 65535)));
      foreach (count_plan[p]) begin
         csr_write(REG_BUCKET_COUNT, count_plan[p]);
         csr_read_check(REG_BUCKET_COUNT, bucket_setting);
         produced = 0;
         while (produced < PHASE_ITEMS) add_random_key(produced);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("string_key_bucket_hash test passed");
      end else begin
         $display("string_key_bucket_hash test failed");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/skbh_pkg.sv
hw/rtl/skbh_if.sv
hw/rtl/skbh_front.sv
hw/rtl/skbh_queue.sv
hw/rtl/skbh_back.sv
hw/rtl/string_key_bucket_hash.sv
dv/string_key_bucket_hash_tb.sv
